// ===== design/oapc_pkg.sv =====
// ----------------------------------------------------------------------------
// oapc_pkg
// shared types, codes and the hash function of the pid cache
// ----------------------------------------------------------------------------
package oapc_pkg;

   localparam int unsigned SLOTS_DEF     = 4096;
   localparam int unsigned NAME_BITS_DEF = 64;
   localparam logic [31:0] HASH_MUL      = 32'd2654435761;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_RETIRE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2,
      ST_ZERO   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_CLEAR,
      BS_READ,
      BS_CHECK,
      BS_WRITE,
      BS_RESULT
   } back_state_type;

   // request as held in the queue between front and back
   typedef struct packed {
      kind_type    kind;
      logic [31:0] pid;
      logic [62:0] create_time;
      logic        name_found;
      logic [63:0] name_handle;
      logic        early;       // answered without probing
      status_type  early_status;
   } req_type;

   function automatic logic [31:0] hash_low(input logic [31:0] pid);
      logic [63:0] prod;
      prod = {34'd0, pid[31:2]} * {32'd0, HASH_MUL};
      return prod[31:0];
   endfunction

endpackage

// ===== design/open_addressed_pid_cache.sv =====
// ----------------------------------------------------------------------------
// open_addressed_pid_cache
// process name cache, open addressing with linear probing and tombstones
// ----------------------------------------------------------------------------
// After reset the block clears every slot of the slot memory before it
// serves a request; the queue in front still takes two beats meanwhile. A
// lookup or retire reads and then checks each probed slot, an insert or retire
// that writes adds a write step; rejected pids and kind 3 are answered without
// a probe. The single port slot memory (read, then compare) sets the pace; a
// two-beat queue lets requests land while the back end probes.
module open_addressed_pid_cache #(
   parameter int unsigned SLOTS     = oapc_pkg::SLOTS_DEF,
   parameter int unsigned NAME_BITS = oapc_pkg::NAME_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] pid, [94:32] create_time, [95] name_found, [159:96] name_handle
   input  logic [159:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [2] hit, [66:3] name_out, [67] retired
   output logic [71:0]  rsp_tdata
);
   import oapc_pkg::*;

   logic    q_valid, q_pop;
   req_type q_head;

   oapc_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_kind(req_tuser), .req_pid(req_tdata[31:0]),
      .req_create_time(req_tdata[94:32]), .req_name_found(req_tdata[95]),
      .req_name_handle(req_tdata[159:96]),
      .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
   );

   oapc_back #(.SLOTS(SLOTS), .NAME_BITS(NAME_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule

// ===== design/oapc_ram.sv =====
// ----------------------------------------------------------------------------
// oapc_ram
// single port ram, registered read
// ----------------------------------------------------------------------------
module oapc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

// ===== design/oapc_front.sv =====
// ----------------------------------------------------------------------------
// oapc_front
// accepts request beats, flags trivial ones, two-entry queue to the back
// ----------------------------------------------------------------------------
module oapc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_kind,
   input  logic [31:0]       req_pid,
   input  logic [62:0]       req_create_time,
   input  logic              req_name_found,
   input  logic [63:0]       req_name_handle,
   output logic              q_valid,
   input  logic              q_pop,
   output oapc_pkg::req_type q_head
);
   import oapc_pkg::*;

   req_type    buf_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   req_type    item;
   logic       push;

   always_comb begin
      item.kind         = kind_type'(req_kind);
      item.pid          = req_pid;
      item.create_time  = req_create_time;
      item.name_found   = req_name_found;
      item.name_handle  = req_name_handle;
      item.early        = 1'b0;
      item.early_status = ST_DONE;
      if (item.kind == KIND_NONE) begin
         item.early = 1'b1;
      end else if (req_pid == 32'd0) begin
         item.early        = 1'b1;
         item.early_status = ST_ZERO;
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_head     = buf_ff[rd_ff];
   assign rd_in      = rd_ff ^ (q_pop && q_valid);
   assign wr_in      = wr_ff ^ push;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wr_ff] <= item;
      end
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overfill");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
endmodule

// ===== design/oapc_back.sv =====
// ----------------------------------------------------------------------------
// oapc_back
// probe sequencer over the slot memory, each slot read and then checked
// ----------------------------------------------------------------------------
module oapc_back #(
   parameter int unsigned SLOTS     = oapc_pkg::SLOTS_DEF,
   parameter int unsigned NAME_BITS = oapc_pkg::NAME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  oapc_pkg::req_type q_head,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata
);
   import oapc_pkg::*;

   localparam int unsigned AW = $clog2(SLOTS);
   localparam int unsigned EW = 32 + 63 + 2 + NAME_BITS;

   back_state_type state_ff, state_in;
   logic [AW-1:0]  slot_ff, slot_in;
   logic [AW:0]    n_ff, n_in;
   logic [71:0]    out_ff, out_in;
   logic           oval_ff, oval_in;
   logic           wr_en;
   logic [EW-1:0]  wr_data, rd_data;
   logic [AW-1:0]  addr;
   logic [31:0]    e_key;
   logic [62:0]    e_time;
   logic           e_res, e_hn;
   logic [NAME_BITS-1:0] e_name;
   logic [31:0]    hsh;

   assign {e_key, e_time, e_res, e_hn, e_name} = rd_data;
   assign hsh = hash_low(q_head.pid);

   oapc_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   assign addr       = slot_ff;
   assign rsp_tvalid = oval_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      n_in     = n_ff;
      out_in   = out_ff;
      oval_in  = oval_ff && !rsp_tready;
      wr_en    = 1'b0;
      wr_data  = '0;
      q_pop    = 1'b0;
      unique case (state_ff)
         BS_CLEAR: begin
            wr_en   = 1'b1;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == AW'(SLOTS - 1)) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (q_valid && !oval_in) begin
               if (q_head.early) begin
                  q_pop   = 1'b1;
                  out_in  = {4'd0, 64'd0, 1'b0, 1'b0, q_head.early_status};
                  oval_in = 1'b1;
               end else begin
                  slot_in  = hsh[AW-1:0];
                  n_in     = '0;
                  state_in = BS_READ;
               end
            end
         end
         BS_READ: state_in = BS_CHECK;
         BS_CHECK: begin
            state_in = BS_RESULT;
            out_in   = '0;
            priority if (q_head.kind == KIND_INSERT) begin
               if (e_key == 32'd0 || e_key == q_head.pid || e_time == 63'd0) begin
                  state_in = BS_WRITE;
                  out_in[1:0] = ST_DONE;
               end else if (n_ff == (AW+1)'(SLOTS - 1)) begin
                  out_in[1:0] = ST_FULL;
               end else begin
                  state_in = BS_READ;
               end
            end else begin
               if (e_key == 32'd0) begin
                  out_in[1:0] = ST_ABSENT;
               end else if (e_key == q_head.pid) begin
                  if (q_head.kind == KIND_LOOKUP) begin
                     if (e_time == q_head.create_time && e_res && e_hn) begin
                        out_in[2]    = 1'b1;
                        out_in[66:3] = 64'(e_name);
                     end
                  end else if (e_time != 63'd0 && e_time != q_head.create_time) begin
                     out_in[67] = 1'b1;
                     state_in   = BS_WRITE;
                  end
               end else if (n_ff == (AW+1)'(SLOTS - 1)) begin
                  out_in[1:0] = ST_ABSENT;
               end else begin
                  state_in = BS_READ;
               end
            end
            if (state_in == BS_READ) begin
               slot_in = slot_ff + 1'b1;
               n_in    = n_ff + 1'b1;
            end
         end
         BS_WRITE: begin
            wr_en = 1'b1;
            if (q_head.kind == KIND_INSERT) begin
               wr_data = {q_head.pid, q_head.create_time, 1'b1, q_head.name_found,
                          q_head.name_found ? q_head.name_handle[NAME_BITS-1:0]
                                            : NAME_BITS'(0)};
            end else begin
               wr_data = {e_key, 63'd0, 2'b00, NAME_BITS'(0)};
            end
            state_in = BS_RESULT;
         end
         BS_RESULT: begin
            if (!oval_in) begin
               oval_in  = 1'b1;
               q_pop    = 1'b1;
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_CLEAR;
         slot_ff  <= '0;
         oval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         oval_ff  <= oval_in;
      end
      n_ff   <= n_in;
      out_ff <= out_in;
   end

   a_pop_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_tvalid) else $error("pop without response");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != BS_CLEAR) |=> state_ff == BS_RESULT) else $error("stray write");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("result changed");
endmodule
